### hw/rtl/npg_pkg.sv
// ----------------------------------------------------------------------------
// npg_pkg: next permutation generator shared types
// Item formats, command codes and fixed field widths.
// ----------------------------------------------------------------------------
package npg_pkg;

	localparam int CNT_W     = 5;   // element count, holds up to RUN_LIMIT
	localparam int IDX_W     = 4;   // position within a run
	localparam int VAL_W     = 16;  // element value
	localparam int RUN_LIMIT = 16;  // longest emitted run

	localparam logic [CNT_W-1:0] CFG_RESET = 5'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]        elem_index;
		logic signed [VAL_W-1:0] elem_value;
		logic                    last_elem;
		logic                    advanced;
	} rsp_t;

endpackage

### hw/rtl/next_permutation_generator_unit.sv
// Load item: accepted with no result.
// Step item over n elements: a pivot scan, then each element emitted in turn with any
// result stall; if a pivot was found, a successor scan, a swap and the reversal of the
// suffix pair by pair follow.
// One item at a time; ready only between items.
// Reset sets cfg_q to 3; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
// next_permutation_generator_unit: next lexicographic permutation
// Holds the element count register, clamps it and runs the step sequencer.
// ----------------------------------------------------------------------------
module next_permutation_generator_unit
	import npg_pkg::*;
#(
	parameter int MAX_ELEMS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int CAP = (MAX_ELEMS < RUN_LIMIT) ? MAX_ELEMS : RUN_LIMIT;

	logic [CNT_W-1:0] cfg_q;
	logic [CNT_W-1:0] active_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	// zero acts as one, large counts saturate
	always_comb begin
		if (cfg_q == '0) begin
			active_cnt = CNT_W'(1);
		end else if (32'(cfg_q) > CAP) begin
			active_cnt = CNT_W'(CAP);
		end else begin
			active_cnt = cfg_q;
		end
	end

	npg_seq #(
		.MAX_ELEMS(MAX_ELEMS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.active_cnt (active_cnt),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

`ifndef SYNTHESIS
	a_no_take_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("item taken while a result is pending");

	a_last_at_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last_elem) |-> ((CNT_W'(rsp.elem_index) + CNT_W'(1)) == active_cnt))
		else $error("last element flag off the run end");

	a_final_run_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && rsp.last_elem && !rsp.advanced) |=> req_ready)
		else $error("not ready after final run without advance");
`endif

endmodule

### hw/rtl/npg_seq.sv
// ----------------------------------------------------------------------------
// npg_seq: permutation store and step sequencer
// Holds the element memory and walks it with one shared signed comparator:
// pivot scan, emit, successor scan, swap and suffix reversal.
// ----------------------------------------------------------------------------
module npg_seq
	import npg_pkg::*;
#(
	parameter int MAX_ELEMS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	input  logic [CNT_W-1:0] active_cnt,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int AW = $clog2(MAX_ELEMS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIVOT,
		S_EM_RD,
		S_EM_LD,
		S_EM_HOLD,
		S_SUCC,
		S_SWAP_A,
		S_SWAP_B,
		S_RV_LO,
		S_RV_HI,
		S_RV_WLO,
		S_RV_WHI
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  n_q;
	logic              found_q;
	logic [IDX_W-1:0]  pivot_q;
	logic [VAL_W-1:0]  pv_val_q;
	logic [VAL_W-1:0]  prev_q;
	logic [IDX_W-1:0]  succ_q;
	logic [VAL_W-1:0]  succ_val_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [VAL_W-1:0]  tmp_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [VAL_W-1:0]  mem [MAX_ELEMS];
	logic [VAL_W-1:0]  rd_data_q;

	logic [IDX_W-1:0]  rd_idx;
	logic              we;
	logic [IDX_W-1:0]  w_idx;
	logic [VAL_W-1:0]  w_data;
	logic [VAL_W-1:0]  cmp_a;
	logic              lt;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// shared comparator: a[k] < a[k+1] in the pivot scan, a[pivot] < a[k] after
	assign cmp_a = (state_q == S_SUCC) ? pv_val_q : prev_q;
	assign lt    = $signed(cmp_a) < $signed(rd_data_q);

	always_comb begin
		unique case (state_q) inside
			S_PIVOT, S_EM_RD, S_SUCC: rd_idx = k_q[IDX_W-1:0];
			S_RV_LO:                  rd_idx = lo_q;
			S_RV_HI:                  rd_idx = hi_q;
			default:                  rd_idx = '0;
		endcase
	end

	always_comb begin
		we     = 1'b0;
		w_idx  = '0;
		w_data = '0;
		unique case (state_q)
			S_IDLE: begin
				we     = req_valid && (req.cmd == CMD_LOAD)
				         && (32'(req.position) < MAX_ELEMS);
				w_idx  = req.position;
				w_data = req.value;
			end
			S_SWAP_A: begin
				we     = 1'b1;
				w_idx  = pivot_q;
				w_data = succ_val_q;
			end
			S_SWAP_B: begin
				we     = 1'b1;
				w_idx  = succ_q;
				w_data = pv_val_q;
			end
			S_RV_WLO: begin
				we     = 1'b1;
				w_idx  = lo_q;
				w_data = rd_data_q;
			end
			S_RV_WHI: begin
				we     = 1'b1;
				w_idx  = hi_q;
				w_data = tmp_q;
			end
			default: begin
				we     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[AW'(w_idx)] <= w_data;
		end
		rd_data_q <= mem[AW'(rd_idx)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
			pivot_q     <= '0;
			pv_val_q    <= '0;
			prev_q      <= '0;
			succ_q      <= '0;
			succ_val_q  <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			tmp_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && (req.cmd == CMD_STEP)) begin
						n_q     <= active_cnt;
						k_q     <= '0;
						found_q <= 1'b0;
						state_q <= S_PIVOT;
					end
				end
				S_PIVOT: begin
					// rd_data_q holds a[k-1], prev_q holds a[k-2]
					if (k_q != '0) begin
						prev_q <= rd_data_q;
					end
					if ((k_q >= CNT_W'(2)) && lt) begin
						found_q  <= 1'b1;
						pivot_q  <= IDX_W'(k_q - CNT_W'(2));
						pv_val_q <= prev_q;
					end
					if (k_q == n_q) begin
						k_q     <= '0;
						state_q <= S_EM_RD;
					end else begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_LD;
				end
				S_EM_LD: begin
					rsp_q.elem_index <= k_q[IDX_W-1:0];
					rsp_q.elem_value <= rd_data_q;
					rsp_q.last_elem  <= (k_q + CNT_W'(1)) == n_q;
					rsp_q.advanced   <= found_q;
					rsp_valid_q      <= 1'b1;
					state_q          <= S_EM_HOLD;
				end
				S_EM_HOLD: begin
					if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
						if (rsp_q.last_elem) begin
							if (found_q) begin
								k_q     <= CNT_W'(pivot_q) + CNT_W'(1);
								state_q <= S_SUCC;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				S_SUCC: begin
					// first cycle only issues the read of a[pivot+1]
					if ((k_q != (CNT_W'(pivot_q) + CNT_W'(1))) && lt) begin
						succ_q     <= IDX_W'(k_q - CNT_W'(1));
						succ_val_q <= rd_data_q;
					end
					if (k_q == n_q) begin
						state_q <= S_SWAP_A;
					end else begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				S_SWAP_A: begin
					state_q <= S_SWAP_B;
				end
				S_SWAP_B: begin
					lo_q <= pivot_q + IDX_W'(1);
					hi_q <= IDX_W'(n_q - CNT_W'(1));
					if ((CNT_W'(pivot_q) + CNT_W'(1)) < (n_q - CNT_W'(1))) begin
						state_q <= S_RV_LO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RV_LO: begin
					state_q <= S_RV_HI;
				end
				S_RV_HI: begin
					tmp_q   <= rd_data_q;
					state_q <= S_RV_WLO;
				end
				S_RV_WLO: begin
					state_q <= S_RV_WHI;
				end
				S_RV_WHI: begin
					lo_q <= lo_q + IDX_W'(1);
					hi_q <= hi_q - IDX_W'(1);
					if ((CNT_W'(lo_q) + CNT_W'(2)) < CNT_W'(hi_q)) begin
						state_q <= S_RV_LO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: next permutation generator regression
// Drives load and step items through the request channel and checks every
// emitted element against an in-bench permutation predictor. The element
// count is rewritten between phases, extremes included. Both channels idle
// at random, and one long result stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
	import npg_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int SETTLE      = 200;   // covers the tail of a 16-element advance
	localparam int STALL_LEN   = 400;
	localparam int PHASES      = 12;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req_item  = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp_item;

	req_t item_backlog[$];
	rsp_t emitted_due[$];

	logic signed [VAL_W-1:0] perm_mem [STORE_DEPTH];
	logic [CNT_W-1:0]        elem_cfg = CFG_RESET;

	int errors      = 0;
	int send_idle   = 0;
	int recv_idle   = 0;
	int steps_taken = 0;
	int stall_left  = 0;
	bit stall_armed = 1'b0;

	next_permutation_generator_unit #(.MAX_ELEMS(STORE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int run_length(logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > STORE_DEPTH)
			return STORE_DEPTH;
		return int'(c);
	endfunction

	// Emit the leading run, then step it to the next lexicographic arrangement.
	function automatic void advance_and_emit();
		int n, pivot, succ, lo, hi;
		bit found;
		logic signed [VAL_W-1:0] snap [STORE_DEPTH];
		logic signed [VAL_W-1:0] t;
		rsp_t e;
		n = run_length(elem_cfg);
		pivot = 0;
		succ = 0;
		found = 1'b0;
		for (int k = 0; k < n; k++)
			snap[k] = perm_mem[k];
		for (int k = 0; k + 1 < n; k++)
			if (perm_mem[k] < perm_mem[k + 1]) begin
				pivot = k;
				found = 1'b1;
			end
		if (found) begin
			for (int k = pivot + 1; k < n; k++)
				if (perm_mem[k] > perm_mem[pivot])
					succ = k;
			t = perm_mem[pivot];
			perm_mem[pivot] = perm_mem[succ];
			perm_mem[succ] = t;
			lo = pivot + 1;
			hi = n - 1;
			while (lo < hi) begin
				t = perm_mem[lo];
				perm_mem[lo] = perm_mem[hi];
				perm_mem[hi] = t;
				lo++;
				hi--;
			end
		end
		for (int k = 0; k < n; k++) begin
			e.elem_index = IDX_W'(k);
			e.elem_value = snap[k];
			e.last_elem  = (k == n - 1);
			e.advanced   = found;
			emitted_due.push_back(e);
		end
	endfunction

	function automatic req_t make_req(logic c, int pos, logic signed [VAL_W-1:0] v);
		req_t r;
		r.cmd      = c;
		r.position = IDX_W'(pos);
		r.value    = v;
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(3))
			0: return VAL_W'($urandom_range(3));
			1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Driver: predict on acceptance, then offer the next item or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_item  <= '0;
		end else begin
			if (req_valid && req_ready) begin
				if (req_item.cmd == CMD_STEP) begin
					advance_and_emit();
					steps_taken++;
				end else begin
					perm_mem[req_item.position] = req_item.value;
				end
			end
			if (!req_valid || req_ready) begin
				if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
					req_item  <= item_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// One long result stall once the block is well under way.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left  <= 0;
			stall_armed <= 1'b0;
		end else if (!stall_armed && steps_taken >= 30 && item_backlog.size() > 4) begin
			stall_armed <= 1'b1;
			stall_left  <= STALL_LEN;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// Monitor: compare each accepted element with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (emitted_due.size() == 0) begin
					$error("unexpected element: index %0d value %0d",
						rsp_item.elem_index, rsp_item.elem_value);
					errors++;
				end else begin
					e = emitted_due.pop_front();
					if (rsp_item.elem_index !== e.elem_index) begin
						$error("elem_index: expected %0d, actual %0d",
							e.elem_index, rsp_item.elem_index);
						errors++;
					end
					if (rsp_item.elem_value !== e.elem_value) begin
						$error("elem_value: expected %0d, actual %0d",
							e.elem_value, rsp_item.elem_value);
						errors++;
					end
					if (rsp_item.last_elem !== e.last_elem) begin
						$error("last_elem: expected %0b, actual %0b",
							e.last_elem, rsp_item.last_elem);
						errors++;
					end
					if (rsp_item.advanced !== e.advanced) begin
						$error("advanced: expected %0b, actual %0b",
							e.advanced, rsp_item.advanced);
						errors++;
					end
				end
			end
			rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_count(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		elem_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	// Hold until every item is in and every element out, then let the advance finish.
	task automatic drain();
		while (item_backlog.size() != 0 || req_valid || emitted_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly full load-then-step sequences over the active run, some noise.
	task automatic fill_random(input int n, input int quota);
		int pushed, steps, span;
		pushed = 0;
		while (pushed < quota) begin
			if ($urandom_range(99) < 80) begin
				for (int k = 0; k < n; k++)
					item_backlog.push_back(make_req(CMD_LOAD, k, pick_value()));
				span = (n == 1) ? 2 : (n == 2) ? 3 : (n == 3) ? 7 : (n == 4) ? 25 : 4;
				steps = $urandom_range(span, 1);
				for (int k = 0; k < steps; k++)
					item_backlog.push_back(make_req(CMD_STEP, 0, '0));
				pushed += n + steps;
			end else begin
				steps = $urandom_range(3, 1);
				for (int k = 0; k < steps; k++)
					item_backlog.push_back(make_req(1'($urandom_range(1)),
						$urandom_range(STORE_DEPTH - 1), VAL_W'($urandom)));
				pushed += steps;
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] count_plan [PHASES];
		count_plan = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd2, 5'd17,
			5'd4, 5'd5, 5'd16, 5'd3, 5'd4, 5'd2};
		for (int k = 0; k < STORE_DEPTH; k++)
			perm_mem[k] = '0;
		send_idle = 28;
		recv_idle = 79;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, a step from the last arrangement, duplicates.
		item_backlog.push_back(make_req(CMD_LOAD, 0, 16'sh8000));
		item_backlog.push_back(make_req(CMD_LOAD, 1, 16'sh0000));
		item_backlog.push_back(make_req(CMD_LOAD, 2, 16'sh7FFF));
		item_backlog.push_back(make_req(CMD_STEP, 0, '0));
		item_backlog.push_back(make_req(CMD_STEP, 0, '0));
		item_backlog.push_back(make_req(CMD_LOAD, 0, 16'sh7FFF));
		item_backlog.push_back(make_req(CMD_LOAD, 1, 16'sh0000));
		item_backlog.push_back(make_req(CMD_LOAD, 2, 16'sh8000));
		item_backlog.push_back(make_req(CMD_STEP, 0, '0));
		item_backlog.push_back(make_req(CMD_LOAD, 0, 16'sh0007));
		item_backlog.push_back(make_req(CMD_LOAD, 1, 16'sh0007));
		item_backlog.push_back(make_req(CMD_LOAD, 2, 16'sh0007));
		item_backlog.push_back(make_req(CMD_STEP, 0, '0));
		for (int k = 3; k < STORE_DEPTH; k++)
			item_backlog.push_back(make_req(CMD_LOAD, k,
				(k % 2 != 0) ? 16'sh5555 : 16'shAAAA));
		item_backlog.push_back(make_req(CMD_STEP, 0, '0));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 4) begin
				send_idle = 79;
				recv_idle = 28;
			end else if (ph == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_count(count_plan[ph]);
			fill_random(run_length(count_plan[ph]), 27);
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
